[src/tlpsc_pkg.sv]
// Shared types and constants of the two-lane parking space counter.
package tlpsc_pkg;

  localparam int unsigned SensW      = 2;
  localparam int unsigned CountW     = 16;
  localparam int unsigned ShownW     = 8;
  localparam int unsigned CfgW       = 8;
  localparam int unsigned NumOps     = 4;
  localparam int unsigned OpIdxW     = 2;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgW-1:0] TotalSpacesReset      = 8'd10;
  localparam logic [CfgW-1:0] InitialAvailableReset = 8'd10;

  localparam logic signed [CountW-1:0] MinCount = 16'sh8000;

  // Sensor patterns of one lane.
  localparam logic [SensW-1:0] PatClear  = 2'd0;
  localparam logic [SensW-1:0] PatFirst  = 2'd1;
  localparam logic [SensW-1:0] PatSecond = 2'd2;

  // Pending flag positions.
  localparam int unsigned PendIn  = 0;
  localparam int unsigned PendOut = 1;

  // Adjustment slots in the order their results leave the block.
  localparam int unsigned OpEntry = 0;
  localparam int unsigned OpExit  = 1;
  localparam int unsigned OpTake  = 2;
  localparam int unsigned OpFree  = 3;

  typedef enum logic {
    CFG_TOTAL_SPACES      = 1'b0,
    CFG_INITIAL_AVAILABLE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [SensW-1:0] entry_lane_sensors;
    logic [SensW-1:0] exit_lane_sensors;
    logic             button_take_space;
    logic             button_free_space;
  } in_item_t;

  typedef struct packed {
    logic signed [CountW-1:0] raw_count;
    logic [ShownW-1:0]        shown_count;
    logic                     last_of_run;
  } out_item_t;

  // One classified sample: which adjustments to make and their direction.
  typedef struct packed {
    logic [NumOps-1:0] ops;
    logic [NumOps-1:0] up;
  } cmd_t;

endpackage

[src/two_lane_parking_space_counter_unit.sv]
// Top level of the two-lane parking space counter.
//
// The input channel takes one sample per transfer: the sensor pair of the entry
// lane, the sensor pair of the exit lane and the two adjust buttons. Each sample
// causes zero to four count adjustments, and each adjustment leaves as one
// transfer on the output channel carrying the raw count, the shown count and a
// flag on the last adjustment of the sample.
// A sample is taken whenever the command queue has room, so a new sample may
// follow in the next cycle. Its results pass through the command queue and then
// the output register; a sample with n adjustments gives n results from the count
// sequencer, one result per cycle while the receiver keeps taking them.
// Samples without adjustments only update the lane state and produce nothing.
// When the receiver stalls, the output register holds its result, the sequencer
// and then the queue fill, and the input stops taking samples.
// Reset clears the lane state and the queue and loads both counts with the
// reset value of initial_available; total_spaces returns to its reset value.
// Writes to total_spaces take effect on the next adjustment.
module two_lane_parking_space_counter_unit
  import tlpsc_pkg::*;
#(
  parameter int unsigned QueueDepthP = QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item,
  input  logic            cfg_we,
  input  cfg_index_t      cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  logic [CfgW-1:0] total_spaces;
  logic            push;
  cmd_t            push_cmd;
  logic            queue_full;
  logic            pop;
  logic            head_valid;
  cmd_t            head_cmd;

  // The initial available count only matters at reset, where it holds its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_spaces <= TotalSpacesReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_SPACES:      total_spaces <= cfg_data;
        CFG_INITIAL_AVAILABLE: ;
        default:               ;
      endcase
    end
  end

  tlpsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  tlpsc_queue #(
    .Depth (QueueDepthP)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tlpsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .total_spaces (total_spaces),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item)
  );

  // A negative count is always shown as zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.raw_count[CountW-1] |-> out_item.shown_count == '0)
    else $error("negative count shown as nonzero");

  // A result that is not the last of its sample leaves its command at the queue head.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last_of_run |-> head_valid)
    else $error("partial command missing from queue head");

  // The queue is only popped when it holds a command.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty command queue");

endmodule

[src/tlpsc_front.sv]
// Front end: tracks both lanes and turns each sample into an adjustment command.
module tlpsc_front
  import tlpsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     push,
  output cmd_t     push_cmd,
  input  logic     queue_full
);

  logic [SensW-1:0] lane_prev [2];
  logic             lane_dir  [2];
  logic [1:0]       lane_pend [2];

  logic [SensW-1:0] sens      [2];
  logic             dir_next  [2];
  logic [1:0]       pend_next [2];
  logic             fire_in   [2];
  logic             fire_out  [2];
  logic             accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign sens[0]  = in_item.entry_lane_sensors;
  assign sens[1]  = in_item.exit_lane_sensors;

  always_comb begin
    logic [1:0] armed;
    logic       chg;
    for (int i = 0; i < 2; i++) begin
      chg         = sens[i] != lane_prev[i];
      dir_next[i] = lane_dir[i];
      armed       = lane_pend[i];
      if (chg && sens[i] == PatFirst) begin
        dir_next[i] = 1'b1;
      end
      if (chg && sens[i] == PatSecond) begin
        dir_next[i] = 1'b0;
      end
      if (chg && sens[i] == PatClear) begin
        if (lane_dir[i]) begin
          armed[PendOut] = 1'b1;
        end else begin
          armed[PendIn] = 1'b1;
        end
      end
      fire_in[i]            = armed[PendIn] && sens[i] == PatFirst;
      fire_out[i]           = armed[PendOut] && sens[i] == PatSecond;
      pend_next[i]          = armed;
      pend_next[i][PendIn]  = armed[PendIn] && !fire_in[i];
      pend_next[i][PendOut] = armed[PendOut] && !fire_out[i];
    end
  end

  always_comb begin
    push_cmd               = '0;
    push_cmd.ops[OpEntry]  = fire_in[0] || fire_out[0];
    push_cmd.up[OpEntry]   = fire_out[0];
    push_cmd.ops[OpExit]   = fire_in[1] || fire_out[1];
    push_cmd.up[OpExit]    = fire_in[1];
    push_cmd.ops[OpTake]   = in_item.button_take_space;
    push_cmd.up[OpTake]    = 1'b0;
    push_cmd.ops[OpFree]   = in_item.button_free_space;
    push_cmd.up[OpFree]    = 1'b1;
  end

  // Samples that cause no adjustment update the lanes and are not queued.
  assign push = accept && (push_cmd.ops != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        lane_prev[i] <= PatClear;
        lane_dir[i]  <= 1'b0;
        lane_pend[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < 2; i++) begin
        lane_prev[i] <= sens[i];
        lane_dir[i]  <= dir_next[i];
        lane_pend[i] <= pend_next[i];
      end
    end
  end

endmodule

[src/tlpsc_queue.sv]
// Command queue between the front end and the count sequencer.
module tlpsc_queue
  import tlpsc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full       = fill == CntW'(Depth);
  assign head_valid = fill != '0;
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[src/tlpsc_back.sv]
// Back end: applies queued adjustments one per cycle while the output is not stalled, and holds the result register.
module tlpsc_back
  import tlpsc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cmd_t            head_cmd,
  output logic            pop,
  input  logic [CfgW-1:0] total_spaces,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item
);

  logic [NumOps-1:0]        done;
  logic [NumOps-1:0]        remaining;
  logic [NumOps-1:0]        sel_mask;
  logic [NumOps-1:0]        rest;
  logic [OpIdxW-1:0]        sel;
  logic                     step;
  logic signed [CountW-1:0] available_raw;
  logic [ShownW-1:0]        available_shown;
  logic signed [CountW-1:0] raw_next;
  logic [ShownW-1:0]        shown_next;
  logic signed [CountW:0]   stepped;
  logic signed [CountW:0]   limit;

  assign remaining = head_cmd.ops & ~done;

  always_comb begin
    sel = '0;
    for (int i = NumOps - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        sel = OpIdxW'(i);
      end
    end
  end

  assign sel_mask = NumOps'(1) << sel;
  assign rest     = remaining & ~sel_mask;
  assign step     = head_valid && (remaining != '0) && (!out_valid || out_ready);
  assign pop      = step && (rest == '0);

  always_comb begin
    limit = {{(CountW + 1 - CfgW){1'b0}}, total_spaces};
    if (head_cmd.up[sel]) begin
      stepped = {available_raw[CountW-1], available_raw} + 1'b1;
    end else if (available_raw != MinCount) begin
      stepped = {available_raw[CountW-1], available_raw} - 1'b1;
    end else begin
      stepped = {available_raw[CountW-1], available_raw};
    end
    shown_next = available_shown;
    raw_next   = stepped[CountW-1:0];
    if (stepped <= limit) begin
      shown_next = stepped[ShownW-1:0];
    end
    if (stepped < 0) begin
      shown_next = '0;
    end
    if (stepped > limit) begin
      raw_next = limit[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done            <= '0;
      out_valid       <= 1'b0;
      available_raw   <= CountW'(InitialAvailableReset);
      available_shown <= InitialAvailableReset;
    end else begin
      if (step) begin
        done            <= (rest == '0) ? '0 : (done | sel_mask);
        out_valid       <= 1'b1;
        available_raw   <= raw_next;
        available_shown <= shown_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item.raw_count   <= raw_next;
      out_item.shown_count <= shown_next;
      out_item.last_of_run <= rest == '0;
    end
  end

endmodule
